FILE: hdl/bank_conflict_degree_counter_macros.svh
// Assertion helpers for the bank conflict degree counter.
`ifndef BANK_CONFLICT_DEGREE_COUNTER_MACROS_SVH
`define BANK_CONFLICT_DEGREE_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low
`define BCDC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bcdc assertion failed");

// Next-cycle implication, disabled while reset is low
`define BCDC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bcdc assertion failed");

`else

`define BCDC_ASSERT_NOW(label, clk, rstn, ante, cons)
`define BCDC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: hdl/bcdc_pkg.sv
package bcdc_pkg;

    localparam int NUM_BANKS       = 32;
    localparam int BANK_WORD_BYTES = 4;
    localparam int MAX_ADDRESSES   = 32;

    localparam int ADDR_W     = 24;
    localparam int WORD_SHIFT = $clog2(BANK_WORD_BYTES);
    localparam int WORD_W     = ADDR_W - WORD_SHIFT;
    localparam int BANK_W     = $clog2(NUM_BANKS);
    localparam int SLOT_W     = $clog2(MAX_ADDRESSES);
    localparam int FILL_W     = $clog2(MAX_ADDRESSES + 1);
    localparam int CNT_W      = 6;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BANK_W-1:0] bank_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam fill_t STORE_FULL = fill_t'(MAX_ADDRESSES);
    localparam cnt_t  COUNT_MAX  = {CNT_W{1'b1}};
    localparam cnt_t  COUNT_ONE  = cnt_t'(1);

    // Per-transaction update handed to the bank counters
    typedef struct packed {
        logic  fire;
        logic  new_word;
        logic  last;
        bank_t bank;
    } bank_step_t;

endpackage

FILE: hdl/bcdc_word_store.sv
module bcdc_word_store
    import bcdc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  fire,
    input  logic  last,
    input  word_t word,
    output logic  new_word
);

    word_t seen_words_reg [MAX_ADDRESSES];
    fill_t seen_count_reg;
    fill_t seen_count_next;
    logic  hit;

    // Compare the word against every filled slot in parallel
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < MAX_ADDRESSES; i++) begin
            if ((fill_t'(i) < seen_count_reg) && (seen_words_reg[i] == word)) begin
                hit = 1'b1;
            end
        end
    end

    assign new_word = !hit && (seen_count_reg != STORE_FULL);

    // Advance the fill count, drop it at the end of a phase
    always_comb begin
        seen_count_next = seen_count_reg;
        if (fire) begin
            if (last) begin
                seen_count_next = '0;
            end else if (new_word) begin
                seen_count_next = seen_count_reg + fill_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_count_reg <= '0;
        end else begin
            seen_count_reg <= seen_count_next;
        end
    end

    // Store a new word in the next free slot
    always_ff @(posedge aclk) begin
        if (fire && new_word) begin
            seen_words_reg[seen_count_reg[SLOT_W-1:0]] <= word;
        end
    end

endmodule

FILE: hdl/bcdc_bank_track.sv
module bcdc_bank_track
    import bcdc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  bank_step_t step,
    output cnt_t       max_next
);

    cnt_t counts_reg [NUM_BANKS];
    cnt_t running_max_reg;
    cnt_t cnt_sel;
    cnt_t cnt_inc;

    // Bump the selected bank count, saturating
    assign cnt_sel = counts_reg[step.bank];
    assign cnt_inc = (cnt_sel == COUNT_MAX) ? cnt_sel : cnt_sel + COUNT_ONE;

    // Running maximum including this transaction
    always_comb begin
        max_next = running_max_reg;
        if (step.new_word && (cnt_inc > running_max_reg)) begin
            max_next = cnt_inc;
        end
    end

    // Update counters, clear them when the phase closes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BANKS; i++) begin
                counts_reg[i] <= '0;
            end
            running_max_reg <= COUNT_ONE;
        end else if (step.fire) begin
            if (step.last) begin
                for (int i = 0; i < NUM_BANKS; i++) begin
                    counts_reg[i] <= '0;
                end
                running_max_reg <= COUNT_ONE;
            end else if (step.new_word) begin
                counts_reg[step.bank] <= cnt_inc;
                running_max_reg       <= max_next;
            end
        end
    end

endmodule

FILE: hdl/bank_conflict_degree_counter.sv
// Channel   Direction  Ports                                    Handshake
// s_        in         s_byte_address[23:0], s_last_address     s_valid / s_ready
// m_        out        m_conflict_degree[5:0]                   m_valid / m_ready
//
// One address per cycle while no flagged address waits on a full output: a
// transaction sits in the input register, where the parallel compare against
// the 32-entry word store and the bank counter update both finish, then the
// result of a flagged address goes to the output register.
// Reset (aresetn low, synchronous) empties the store and clears all counters.
// A waiting result stalls a following flagged address and all input behind it;
// unflagged addresses ahead of it keep flowing.
`include "bank_conflict_degree_counter_macros.svh"

module bank_conflict_degree_counter
    import bcdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_byte_address,
    input  logic        s_last_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_conflict_degree
);

    logic       in_valid_reg;
    logic       in_valid_next;
    addr_t      in_addr_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    cnt_t       out_ways_reg;
    logic       fire;
    logic       new_word;
    word_t      word;
    cnt_t       max_next;
    bank_step_t step;

    // Process the held transaction unless it is a flagged one facing a full output
    assign fire    = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    assign word = in_addr_reg[ADDR_W-1:WORD_SHIFT];

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign out_valid_next = (fire && in_last_reg) ? 1'b1
                          : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the payload, and the result when a phase closes
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_addr_reg <= s_byte_address;
            in_last_reg <= s_last_address;
        end
        if (fire && in_last_reg) begin
            out_ways_reg <= max_next;
        end
    end

    bcdc_word_store u_word_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .last     (in_last_reg),
        .word     (word),
        .new_word (new_word)
    );

    assign step = {fire, new_word, in_last_reg, word[BANK_W-1:0]};

    bcdc_bank_track u_bank_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .max_next (max_next)
    );

    assign m_valid           = out_valid_reg;
    assign m_conflict_degree = out_ways_reg;

    // Closing a phase loads the result register with the updated maximum
    `BCDC_ASSERT_NEXT(a_result_load, aclk, aresetn, fire && in_last_reg, m_valid && (m_conflict_degree == $past(max_next)))

    // Input side only stalls behind a flagged address blocked by the output
    `BCDC_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready, in_valid_reg && in_last_reg && m_valid && !m_ready)

    // Conflict degree stays between one and the store depth
    `BCDC_ASSERT_NOW(a_ways_range, aclk, aresetn, m_valid, (m_conflict_degree != '0) && (m_conflict_degree <= cnt_t'(MAX_ADDRESSES)))

endmodule

FILE: bench/testbench.sv
import bcdc_pkg::*;

// Tracks the distinct words of the current access phase and the expected
// conflict degree of every finished phase
class conflict_degree_tracker;
    word_t       phase_words[MAX_ADDRESSES];
    int unsigned phase_fill;
    cnt_t        bank_counts[NUM_BANKS];
    cnt_t        peak_ways;
    cnt_t        pending_ways[$];
    int unsigned mismatch_count;

    function new();
        mismatch_count = 0;
        clear_phase();
    endfunction

    function void clear_phase();
        foreach (bank_counts[b]) bank_counts[b] = '0;
        phase_fill = 0;
        peak_ways  = COUNT_ONE;
    endfunction

    // Fold one accepted address into the phase; queue the degree on the last one
    function void note_address(addr_t byte_addr, logic last_addr);
        word_t       word;
        int unsigned bank;
        bit          known;
        word  = word_t'(byte_addr / BANK_WORD_BYTES);
        bank  = word % NUM_BANKS;
        known = 1'b0;
        for (int unsigned i = 0; i < phase_fill; i++) begin
            if (phase_words[i] == word) known = 1'b1;
        end
        // Count a new word only while the store has room
        if (!known && phase_fill < MAX_ADDRESSES) begin
            phase_words[phase_fill] = word;
            phase_fill++;
            if (bank_counts[bank] < COUNT_MAX) bank_counts[bank]++;
            if (bank_counts[bank] > peak_ways) peak_ways = bank_counts[bank];
        end
        if (last_addr) begin
            pending_ways.push_back(peak_ways);
            clear_phase();
        end
    endfunction

    // Compare one result transaction against the oldest expected degree
    function void check_ways(cnt_t actual);
        cnt_t expected;
        if (pending_ways.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected conflict degree result: actual %0d", actual);
        end else begin
            expected = pending_ways.pop_front();
            if (actual !== expected) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("conflict degree differs: expected %0d, actual %0d",
                             expected, actual);
            end
        end
    endfunction

    // Charge every degree that never came out
    function void close_out();
        foreach (pending_ways[k]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("conflict degree missing: expected %0d", pending_ways[k]);
        end
    endfunction
endclass

module testbench;

    localparam int unsigned ITEM_TARGET  = 1550;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef enum int {
        STYLE_NOISE,
        STYLE_ONE_BANK,
        STYLE_STRIDE,
        STYLE_POOL,
        STYLE_DENSE
    } phase_style_t;

    typedef enum int {
        SINK_READY,
        SINK_COIN,
        SINK_THIRD,
        SINK_BURSTY
    } sink_mode_t;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [23:0] s_byte_address = '0;
    logic        s_last_address = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [5:0]  m_conflict_degree;

    conflict_degree_tracker tracker = new();

    int unsigned burst_left   = 0;
    int unsigned items_sent   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned pattern_left = 0;
    int unsigned stall_left   = 0;
    int unsigned third_tick   = 0;
    sink_mode_t  sink_mode    = SINK_READY;

    bank_conflict_degree_counter u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_byte_address    (s_byte_address),
        .s_last_address    (s_last_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_conflict_degree (m_conflict_degree)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Present one address and hold it until the transaction completes
    task automatic send_address(input addr_t byte_addr, input logic last_addr);
        int unsigned gap;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end
        s_valid        <= 1'b1;
        s_byte_address <= byte_addr;
        s_last_address <= last_addr;
        burst_left--;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Send one access phase whose addresses follow a typical access shape
    task automatic send_phase(input int unsigned len, input phase_style_t style);
        int unsigned strides[8] = '{4, 8, 12, 64, 128, 132, 256, 1024};
        word_t       pool[8];
        word_t       word;
        bank_t       bank;
        addr_t       base;
        addr_t       byte_addr;
        int unsigned stride;
        bank   = bank_t'($urandom);
        base   = addr_t'($urandom);
        stride = strides[$urandom_range(0, 7)];
        foreach (pool[k]) pool[k] = word_t'($urandom);
        for (int unsigned i = 0; i < len; i++) begin
            word = word_t'($urandom);
            case (style)
                STYLE_NOISE: begin
                    byte_addr = addr_t'($urandom);
                end
                STYLE_ONE_BANK: begin
                    if ($urandom_range(0, 1) == 0)
                        word = word_t'($urandom_range(0, 15)) << BANK_W;
                    word[BANK_W-1:0] = bank;
                    byte_addr = addr_t'(word * BANK_WORD_BYTES
                                        + $urandom_range(0, BANK_WORD_BYTES - 1));
                end
                STYLE_STRIDE: begin
                    byte_addr = base + addr_t'(i * stride);
                end
                STYLE_POOL: begin
                    byte_addr = addr_t'(pool[$urandom_range(0, 7)] * BANK_WORD_BYTES
                                        + $urandom_range(0, BANK_WORD_BYTES - 1));
                end
                default: begin
                    byte_addr = addr_t'($urandom_range(0, 255) * BANK_WORD_BYTES
                                        + $urandom_range(0, BANK_WORD_BYTES - 1));
                end
            endcase
            send_address(byte_addr, i == len - 1);
        end
    endtask

    // Sample both channels at the edge where the transaction completes
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            tracker.note_address(s_byte_address, s_last_address);
        if (aresetn && m_valid && m_ready)
            tracker.check_ways(m_conflict_degree);
    end

    // Stall the result channel on a pattern that changes at random intervals
    always @(posedge aclk) begin
        if (pattern_left == 0) begin
            sink_mode    = sink_mode_t'($urandom_range(0, 3));
            pattern_left = $urandom_range(50, 400);
        end else begin
            pattern_left--;
        end
        third_tick = (third_tick == 2) ? 0 : third_tick + 1;
        case (sink_mode)
            SINK_READY: m_ready <= 1'b1;
            SINK_COIN:  m_ready <= ($urandom_range(0, 1) == 1);
            SINK_THIRD: m_ready <= (third_tick == 0);
            default: begin
                if (stall_left != 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 16);
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    // End the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        word_t word;
        int unsigned len;
        int unsigned pick;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Single-address phases at both ends of the address range
        send_address(24'h000000, 1'b1);
        send_address(24'hFFFFFF, 1'b1);

        // Repeated word: three bytes of one word count once
        send_address(24'h000100, 1'b0);
        send_address(24'h000101, 1'b0);
        send_address(24'h000103, 1'b1);

        // Two words in bank zero plus one elsewhere
        send_address(24'h000000, 1'b0);
        send_address(24'h000080, 1'b0);
        send_address(24'h000004, 1'b1);

        // Fill the store with one bank, then offer a new word that must be dropped
        for (int unsigned k = 0; k < MAX_ADDRESSES; k++) begin
            word = (k == MAX_ADDRESSES - 1) ? '1 : word_t'((k << BANK_W) | (NUM_BANKS - 1));
            send_address(addr_t'(word * BANK_WORD_BYTES + (k % BANK_WORD_BYTES)), 1'b0);
        end
        send_address(24'h000000, 1'b1);

        // Random phases of varied shape and length
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                len = 1;
            else if (pick == 1)
                len = $urandom_range(MAX_ADDRESSES + 1, MAX_ADDRESSES + 8);
            else
                len = $urandom_range(2, MAX_ADDRESSES);
            send_phase(len, phase_style_t'($urandom_range(0, 4)));
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then allow the pipeline to settle
        while (tracker.pending_ways.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        tracker.close_out();
        if (tracker.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/bcdc_pkg.sv
hdl/bcdc_word_store.sv
hdl/bcdc_bank_track.sv
hdl/bank_conflict_degree_counter.sv
bench/testbench.sv
